@@ design/itoa_pkg.sv @@
// itoa_pkg: shared constants for the signed integer to decimal ascii block
// no dependencies; imported by the converter, emitter, top and testbench
`default_nettype none

package itoa_pkg;

  // ascii codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // one bcd digit
  localparam int unsigned DIGIT_W = 4;

  // binary bits folded into the bcd register per cycle
  localparam int unsigned STEP_BITS = 4;

  // bcd adjust threshold and correction
  localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [DIGIT_W-1:0] BCD_ADJ_ADD = 4'd3;

endpackage

`default_nettype wire

@@ design/itoa_front.sv @@
// itoa_front: input register that splits each value into sign and magnitude
// no package dependencies
`default_nettype none

module itoa_front #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic signed [VALUE_WIDTH-1:0] value_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic                          neg_o,
  output      logic        [VALUE_WIDTH-1:0] mag_o
);

  logic                   valid_q, valid_d;
  logic                   neg_q, neg_d;
  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic [VALUE_WIDTH-1:0] raw;
  logic                   take;

  assign raw        = value_i;
  assign in_ready_o = !valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  // magnitude of the most negative value still fits as unsigned
  always_comb begin
    neg_d   = neg_q;
    mag_d   = mag_q;
    valid_d = valid_q;
    if (take) begin
      neg_d   = raw[VALUE_WIDTH-1];
      mag_d   = raw[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - raw) : raw;
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    mag_q <= mag_d;
  end

  assign out_valid_o = valid_q;
  assign neg_o       = neg_q;
  assign mag_o       = mag_q;

endmodule

`default_nettype wire

@@ design/itoa_queue.sv @@
// itoa_queue: small flop-based fifo between the front and the conversion unit
// no package dependencies
`default_nettype none

module itoa_queue #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_ready_o,
  input  wire logic [WIDTH-1:0] in_data_i,
  output      logic             out_valid_o,
  input  wire logic             out_ready_i,
  output      logic [WIDTH-1:0] out_data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             push, pop;

  assign in_ready_o  = (count_q != CW'(DEPTH));
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

`default_nettype wire

@@ design/itoa_conv.sv @@
// itoa_conv: iterative binary to bcd converter (shift and add-3), four bits per cycle
// depends on itoa_pkg for digit width and step size
`default_nettype none

module itoa_conv
  import itoa_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned NUM_DIGITS  = 10
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic                          neg_i,
  input  wire logic [VALUE_WIDTH-1:0]        mag_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic                          neg_o,
  output      logic [NUM_DIGITS*DIGIT_W-1:0] bcd_o
);

  localparam int unsigned STEPS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int unsigned PAD_W = STEPS * STEP_BITS;
  localparam int unsigned BCD_W = NUM_DIGITS * DIGIT_W;
  localparam int unsigned SCW   = (STEPS > 1) ? $clog2(STEPS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } conv_state_e;

  conv_state_e      state_q, state_d;
  logic [SCW-1:0]   step_q, step_d;
  logic [PAD_W-1:0] sh_q, sh_d;
  logic [BCD_W-1:0] bcd_q, bcd_d;
  logic             neg_q, neg_d;
  logic [PAD_W-1:0] nx_sh;
  logic [BCD_W-1:0] nx_bcd;

  // STEP_BITS rounds of add-3 then shift
  always_comb begin
    nx_sh  = sh_q;
    nx_bcd = bcd_q;
    for (int b = 0; b < STEP_BITS; b++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (nx_bcd[d*DIGIT_W +: DIGIT_W] >= BCD_ADJ_MIN) begin
          nx_bcd[d*DIGIT_W +: DIGIT_W] = nx_bcd[d*DIGIT_W +: DIGIT_W] + BCD_ADJ_ADD;
        end
      end
      nx_bcd = {nx_bcd[BCD_W-2:0], nx_sh[PAD_W-1]};
      nx_sh  = {nx_sh[PAD_W-2:0], 1'b0};
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    sh_d    = sh_q;
    bcd_d   = bcd_q;
    neg_d   = neg_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          sh_d    = PAD_W'(mag_i);
          bcd_d   = '0;
          neg_d   = neg_i;
          step_d  = '0;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        sh_d   = nx_sh;
        bcd_d  = nx_bcd;
        step_d = step_q + SCW'(1);
        if (step_q == SCW'(STEPS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_DONE);
  assign neg_o       = neg_q;
  assign bcd_o       = bcd_q;

endmodule

`default_nettype wire

@@ design/itoa_emit.sv @@
// itoa_emit: output stage that walks the bcd digits and sends one character per item
// depends on itoa_pkg for ascii codes and digit width
`default_nettype none

module itoa_emit
  import itoa_pkg::*;
#(
  parameter int unsigned NUM_DIGITS = 10
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic                          neg_i,
  input  wire logic [NUM_DIGITS*DIGIT_W-1:0] bcd_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [7:0]                    character_o,
  output      logic                          last_o
);

  localparam int unsigned BCD_W = NUM_DIGITS * DIGIT_W;
  localparam int unsigned IW    = $clog2(NUM_DIGITS);

  logic             busy_q, busy_d;
  logic             sign_q, sign_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic [BCD_W-1:0] bcd_q, bcd_d;
  logic [IW-1:0]    top_idx;
  logic [DIGIT_W-1:0] digit;
  logic             fire, load;

  // leading digit position, zero when the whole value is zero
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd_i[d*DIGIT_W +: DIGIT_W] != '0) begin
        top_idx = IW'(d);
      end
    end
  end

  assign digit       = bcd_q[idx_q*DIGIT_W +: DIGIT_W];
  assign out_valid_o = busy_q;
  assign character_o = sign_q ? CHAR_MINUS : (CHAR_ZERO + 8'(digit));
  assign last_o      = !sign_q && (idx_q == '0);
  assign fire        = out_valid_o && out_ready_i;
  assign in_ready_o  = !busy_q || (fire && last_o);
  assign load        = in_valid_i && in_ready_o;

  always_comb begin
    busy_d = busy_q;
    sign_d = sign_q;
    idx_d  = idx_q;
    bcd_d  = bcd_q;
    if (fire) begin
      if (sign_q) begin
        sign_d = 1'b0;
      end else if (idx_q == '0) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q - IW'(1);
      end
    end
    if (load) begin
      busy_d = 1'b1;
      sign_d = neg_i;
      idx_d  = top_idx;
      bcd_d  = bcd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sign_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      sign_q <= sign_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
  end

  // only a sign or a decimal digit ever leaves
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (character_o == CHAR_MINUS) ||
                    ((character_o >= CHAR_ZERO) && (character_o <= CHAR_ZERO + 8'd9)))
    else $error("character out of range");

  // a sign is always followed by at least one digit
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (character_o == CHAR_MINUS)) |-> !last_o)
    else $error("minus sign flagged last");

  // a number's text never breaks off before its last character
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !last_o) |=> out_valid_o)
    else $error("gap inside a number's text");

endmodule

`default_nettype wire

@@ design/signed_int_to_decimal_ascii.sv @@
// signed_int_to_decimal_ascii: top level of the signed integer to decimal text converter
// depends on itoa_pkg, itoa_front, itoa_queue, itoa_conv and itoa_emit
//
// usage:
//   input channel  : in_valid_i / in_ready_o with value_i, one signed two's complement
//                    integer per item
//   output channel : out_valid_o / out_ready_i with character_o and last_o, one ascii
//                    character per item, most significant first, '-' ahead of a
//                    negative value, no leading zeros, last_o high on the final digit
//   path           : after the value is taken, the first character passes through the
//                    front register, the queue, the conversion loop and the emitter
//   rate           : set by the shift-and-add-3 loop, which folds four bits per cycle,
//                    and by the output of one character per cycle while out_ready_i
//                    is high; the converter works on the next number while the
//                    previous one is still being sent
//   stalls         : when out_ready_i is low the current character holds; the
//                    converter finishes the next number and the front plus queue
//                    keep taking inputs until they fill
//   reset          : rst_ni clears all control state; no clearing pass is needed
`default_nettype none

module signed_int_to_decimal_ascii
  import itoa_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic signed [VALUE_WIDTH-1:0] value_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [7:0]                    character_o,
  output      logic                          last_o
);

  // decimal digits of 2^VALUE_WIDTH, log10(2) ~ 0.30103, covers every magnitude
  localparam int unsigned NUM_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned BCD_W       = NUM_DIGITS * DIGIT_W;
  localparam int unsigned QUEUE_DEPTH = 2;

  // front register to queue
  logic                   fr_valid, fr_ready;
  logic                   fr_neg;
  logic [VALUE_WIDTH-1:0] fr_mag;

  // queue to converter, sign on top of the magnitude
  logic                   q_valid, q_ready;
  logic [VALUE_WIDTH:0]   q_data;

  // converter to emitter
  logic                   cv_valid, cv_ready;
  logic                   cv_neg;
  logic [BCD_W-1:0]       cv_bcd;

  // front: accept and split into sign and magnitude
  itoa_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .out_valid_o(fr_valid),
    .out_ready_i(fr_ready),
    .neg_o      (fr_neg),
    .mag_o      (fr_mag)
  );

  // decoupling queue so the front keeps accepting while the back is busy
  itoa_queue #(
    .WIDTH(VALUE_WIDTH + 1),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (fr_valid),
    .in_ready_o (fr_ready),
    .in_data_i  ({fr_neg, fr_mag}),
    .out_valid_o(q_valid),
    .out_ready_i(q_ready),
    .out_data_o (q_data)
  );

  // back: binary to bcd, overlaps with emission of the previous number
  itoa_conv #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .NUM_DIGITS (NUM_DIGITS)
  ) u_conv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (q_valid),
    .in_ready_o (q_ready),
    .neg_i      (q_data[VALUE_WIDTH]),
    .mag_i      (q_data[VALUE_WIDTH-1:0]),
    .out_valid_o(cv_valid),
    .out_ready_i(cv_ready),
    .neg_o      (cv_neg),
    .bcd_o      (cv_bcd)
  );

  // back: character sequencer and output register
  itoa_emit #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cv_valid),
    .in_ready_o (cv_ready),
    .neg_i      (cv_neg),
    .bcd_i      (cv_bcd),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .character_o(character_o),
    .last_o     (last_o)
  );

endmodule

`default_nettype wire

@@ test/signed_int_to_decimal_ascii_tb.sv @@
// signed_int_to_decimal_ascii_tb: self-checking testbench for the signed integer to decimal text block
// depends on itoa_pkg and signed_int_to_decimal_ascii; predicts each character and compares in order
`default_nettype none

module signed_int_to_decimal_ascii_tb
  import itoa_pkg::*;
();

  localparam int unsigned VALUE_WIDTH = 32;

  // one expected output item, with the number it came from for messages
  typedef struct {
    logic [7:0]                    ch;
    logic                          last;
    logic signed [VALUE_WIDTH-1:0] src;
  } text_char_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [VALUE_WIDTH-1:0] value_d = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [7:0]                    out_char;
  logic                          out_last;

  text_char_t expected_text[$];
  int         mismatch_count = 0;
  bit         tx_idle_on = 1'b1;
  bit         rx_idle_on = 1'b1;
  int         rx_hold_left = 0;

  signed_int_to_decimal_ascii #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .value_i    (value_d),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .character_o(out_char),
    .last_o     (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // generous bound on the whole run
  initial begin
    #3000000;
    $display("signed_int_to_decimal_ascii_tb: FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic signed [VALUE_WIDTH-1:0] src,
                                 input logic [31:0] exp_v, input logic [31:0] got_v);
    $display("mismatch: %s for %0d, expected %0h got %0h", what, src, exp_v, got_v);
    mismatch_count++;
  endtask

  // decimal text of one number: optional sign, then digits msb first, last on the final digit
  function automatic void predict_decimal_text(input logic signed [VALUE_WIDTH-1:0] v);
    logic [VALUE_WIDTH-1:0] mag;
    logic [3:0]             digits[20];
    int                     nd;
    text_char_t             c;
    mag = v[VALUE_WIDTH-1] ? (~v + 1'b1) : v;
    nd = 0;
    do begin
      digits[nd] = 4'(mag % 10);
      nd++;
      mag = mag / 10;
    end while (mag != 0);
    c.src = v;
    if (v[VALUE_WIDTH-1]) begin
      c.ch   = CHAR_MINUS;
      c.last = 1'b0;
      expected_text.push_back(c);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      c.ch   = CHAR_ZERO + 8'(digits[i]);
      c.last = (i == 0);
      expected_text.push_back(c);
    end
  endfunction

  // called just after a rising edge; returns just after the edge that took the item
  task automatic send_value(input logic signed [VALUE_WIDTH-1:0] v);
    bit accepted;
    while (tx_idle_on && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value_d  <= v;
    accepted = 1'b0;
    while (!accepted) begin
      @(negedge clk);
      accepted = in_ready;
      @(posedge clk);
    end
    predict_decimal_text(v);
  endtask

  // mix of full range, short numbers and values near powers of ten
  function automatic logic signed [VALUE_WIDTH-1:0] random_value();
    int unsigned                   pow10;
    logic signed [VALUE_WIDTH-1:0] v;
    pow10 = 1;
    repeat ($urandom_range(0, 9)) pow10 = pow10 * 10;
    case ($urandom_range(0, 4))
      0:       v = $urandom();
      1:       v = $urandom_range(0, 99);
      2:       v = $urandom_range(0, pow10);
      3:       v = pow10 - $urandom_range(0, 1);
      default: v = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  // receiver: random stalls, plus a long hold-off when asked
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        out_ready <= 1'b0;
        rx_hold_left--;
      end else if (rx_idle_on && $urandom_range(0, 99) < 28) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // outputs are stable at the falling edge; the item moves at the next rising edge
  always @(negedge clk) begin : check_output
    text_char_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_text.size() == 0) begin
        report_mismatch("character with no number pending", '0, 32'h0, {24'h0, out_char});
      end else begin
        e = expected_text.pop_front();
        if (out_char !== e.ch)
          report_mismatch("character", e.src, {24'h0, e.ch}, {24'h0, out_char});
        if (out_last !== e.last)
          report_mismatch("last flag", e.src, {31'h0, e.last}, {31'h0, out_last});
      end
    end
  end

  task automatic test_directed();
    logic signed [VALUE_WIDTH-1:0] vals[] = '{
      0, 1, -1, 9, -9, 10, -10, 99, 100, 7, 42,
      32'sh7fff_ffff, 32'sh8000_0000, -2147483647, 2147483646,
      1000000000, 999999999, -999999999, -1000000000,
      123456789, -1234567890, 65535, -65536};
    foreach (vals[i]) send_value(vals[i]);
  endtask

  task automatic test_random(input int count);
    repeat (count) send_value(random_value());
  endtask

  // both sides at full rate
  task automatic test_no_idle(input int count);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (count) send_value(random_value());
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // receiver holds off long enough that the block fills and stalls its input
  task automatic test_backpressure(input int count);
    in_valid <= 1'b0;
    @(negedge clk);
    rx_hold_left = 400;
    @(posedge clk);
    repeat (count) send_value(random_value());
  endtask

  initial begin
    int drain_cycles;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(57);
    test_no_idle(60);
    test_backpressure(30);
    test_random(40);

    in_valid <= 1'b0;
    drain_cycles = 0;
    while (expected_text.size() != 0 && drain_cycles < 20000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (40) @(posedge clk);
    if (expected_text.size() != 0)
      report_mismatch("characters never emitted", expected_text[0].src,
                      expected_text.size(), 32'h0);

    if (mismatch_count == 0) begin
      $display("signed_int_to_decimal_ascii_tb: PASS");
    end else begin
      $display("signed_int_to_decimal_ascii_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
